FILE: hw/rtl/crc_checked_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC checked frame parser
// Shared property forms used by the checker; they sample on i_clk and
// are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_PARSER_DEFINES_SVH
`define CRC_CHECKED_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define CFP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication.
`define CFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

FILE: hw/rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// CRC checked frame parser package
// Types, constants and the byte-wide CRC-32 update shared by the design.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int MAX_PAYLOAD = 1024;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int FLEN_W   = 11;
    localparam int PIDX_W   = 10;
    localparam int CRC_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0]  FLEN_SAT   = LEN_W'((1 << FLEN_W) - 1);
    localparam logic [CRC_W-1:0]  CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hEDB8_8320;
    localparam logic [BYTE_W-1:0] START_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] END_RST    = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC    = 3'd5,
        PH_END    = 3'd6
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 3'd0,
        ST_GOOD    = 3'd1,
        ST_BAD_CRC = 3'd2,
        ST_BAD_END = 3'd3,
        ST_BAD_LEN = 3'd4
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   frame_type;
        logic [FLEN_W-1:0]   frame_length;
        logic [CRC_W-1:0]    frame_crc;
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [PIDX_W-1:0]   payload_index;
    } t_result;

    // Reflected CRC-32 update over one byte, one bit per step.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/crc_checked_frame_parser.sv
// ----------------------------------------------------------------------------
// CRC checked frame parser
// Byte-serial parser for start/end delimited frames with a CRC-32 check.
//
//   Channel  Direction  Handshake               Word
//   in       input      i_in_valid/o_in_ready   i_rx_byte
//   out      output     o_out_valid/i_out_ready status, frame fields, payload echo
//   cfg      input      i_cfg_we                i_cfg_addr, i_cfg_wdata
//
// A word is captured in the input register and is then parsed into the result
// register, from which its result is offered. One word per cycle is sustained
// while the output is ready; the byte-wide CRC update sets the path.
// Reset is synchronous and restores the delimiters and the frame state.
// A stalled output holds its result and stops the input once both
// registers are full.
// ----------------------------------------------------------------------------
module crc_checked_frame_parser
    import cfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_frame_type,
    output logic [FLEN_W-1:0]    o_frame_length,
    output logic [CRC_W-1:0]     o_frame_crc,
    output logic                 o_payload_valid,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [PIDX_W-1:0]    o_payload_index
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           res;
    logic              fire;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RST;
            r_end_byte   <= END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_BYTE: r_start_byte <= i_cfg_wdata;
                CFG_END_BYTE:   r_end_byte   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    cfp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_frame_type    = r_out.frame_type;
    assign o_frame_length  = r_out.frame_length;
    assign o_frame_crc     = r_out.frame_crc;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;

endmodule

FILE: hw/rtl/cfp_core.sv
// ----------------------------------------------------------------------------
// Frame parser core
// Holds the frame state and turns one byte into one result per fire.
// ----------------------------------------------------------------------------
module cfp_core
    import cfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_start_byte,
    input  logic [BYTE_W-1:0] i_end_byte,
    output t_result           o_res
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_seen, n_seen;
    logic [CRC_W-1:0]  r_rcrc, n_rcrc;
    logic [CRC_W-1:0]  r_crc, n_crc;

    logic [LEN_W-1:0]  len_full;
    logic [CNT_W-1:0]  count_inc;
    logic              finish;

    assign len_full  = {i_byte, r_len[BYTE_W-1:0]};
    assign count_inc = r_count + CNT_W'(1);

    always_comb begin
        n_phase = r_phase;
        finish  = 1'b0;
        unique case (r_phase)
            PH_TYPE:   n_phase = PH_LEN_LO;
            PH_LEN_LO: n_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                if (len_full > LEN_LIMIT) begin
                    finish  = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = (len_full != '0) ? PH_DATA : PH_CRC;
                end
            end
            PH_DATA: begin
                if (LEN_W'(count_inc) >= r_len) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                if (r_seen == 2'd3) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                finish  = 1'b1;
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (i_byte == i_start_byte) ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    always_comb begin
        n_type  = r_type;
        n_len   = r_len;
        n_count = r_count;
        n_seen  = r_seen;
        n_rcrc  = r_rcrc;
        n_crc   = r_crc;
        o_res   = '0;
        o_res.status = ST_NONE;
        case (r_phase)
            PH_TYPE:   n_type = i_byte;
            PH_LEN_LO: n_len  = {{(LEN_W-BYTE_W){1'b0}}, i_byte};
            PH_LEN_HI: begin
                n_len = len_full;
                if (len_full > LEN_LIMIT) begin
                    o_res.status = ST_BAD_LEN;
                end else begin
                    n_count = '0;
                    n_seen  = '0;
                end
            end
            PH_DATA: begin
                o_res.payload_valid = 1'b1;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = PIDX_W'(r_count);
                n_crc   = crc_byte(r_crc, i_byte);
                n_count = count_inc;
                if (LEN_W'(count_inc) >= r_len) begin
                    n_seen = '0;
                end
            end
            PH_CRC: begin
                case (r_seen)
                    2'd0:    n_rcrc = r_rcrc | {24'h0, i_byte};
                    2'd1:    n_rcrc = r_rcrc | {16'h0, i_byte, 8'h0};
                    2'd2:    n_rcrc = r_rcrc | {8'h0, i_byte, 16'h0};
                    default: n_rcrc = r_rcrc | {i_byte, 24'h0};
                endcase
                n_seen = r_seen + 2'd1;
            end
            PH_END: begin
                if (i_byte == i_end_byte) begin
                    o_res.status = ((r_crc ^ CRC_INIT) == r_rcrc) ? ST_GOOD : ST_BAD_CRC;
                end else begin
                    o_res.status = ST_BAD_END;
                end
                o_res.frame_crc = r_rcrc;
            end
            default: ;
        endcase
        o_res.frame_type   = n_type;
        o_res.frame_length = (n_len > FLEN_SAT) ? FLEN_SAT[FLEN_W-1:0] : n_len[FLEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_type  <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_seen  <= '0;
            r_rcrc  <= '0;
            r_crc   <= CRC_INIT;
        end else if (i_fire) begin
            r_phase <= n_phase;
            if (finish) begin
                r_type  <= '0;
                r_len   <= '0;
                r_count <= '0;
                r_seen  <= '0;
                r_rcrc  <= '0;
                r_crc   <= CRC_INIT;
            end else begin
                r_type  <= n_type;
                r_len   <= n_len;
                r_count <= n_count;
                r_seen  <= n_seen;
                r_rcrc  <= n_rcrc;
                r_crc   <= n_crc;
            end
        end
    end

endmodule

FILE: hw/rtl/cfp_checker.sv
// ----------------------------------------------------------------------------
// Frame parser port checker
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_parser_defines.svh"

module cfp_checker
    import cfp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [STATUS_W-1:0]  o_status,
    input logic [FLEN_W-1:0]    o_frame_length,
    input logic [CRC_W-1:0]     o_frame_crc,
    input logic                 o_payload_valid,
    input logic [BYTE_W-1:0]    o_payload_byte,
    input logic [PIDX_W-1:0]    o_payload_index
);

    `CFP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `CFP_ASSERT_IMPL(a_payload_no_status, o_out_valid && o_payload_valid, o_status == ST_NONE && o_frame_crc == '0)
    `CFP_ASSERT_IMPL(a_idle_echo_zero, o_out_valid && !o_payload_valid, o_payload_byte == '0 && o_payload_index == '0)
    `CFP_ASSERT_IMPL(a_bad_len_shape, o_out_valid && o_status == ST_BAD_LEN, o_frame_crc == '0 && o_frame_length > FLEN_W'(MAX_PAYLOAD))

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (.*);
